// ----- sv/assert_macros.svh -----
// Assertion helpers for the retransmit buffer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AST_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define AST_CLK(label, clk, rst_n, prop, msg)
`define AST_IMPL(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- sv/asrb_pkg.sv -----
package asrb_pkg;

    localparam int RingDepthDef = 2048;
    localparam int ScanLimitDef = 128;
    localparam logic [15:0] ReplayReset = 16'd100;
    localparam logic [15:0] MaxSize = 16'd64;
    localparam logic [31:0] SeqLast = 32'hffff_ffff;

    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,
        OP_SELECT = 2'd1,
        OP_FRAME  = 2'd2,
        OP_ACK    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERSIZE  = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_REJECTED  = 3'd4,
        ST_NOTHING   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_SCAN,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [7:0]  sample_type;
        logic [15:0] sample_size;
        logic [63:0] sample_stamp;
        logic [31:0] ack_sequence;
        logic        frame_completed;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] slot;
        logic [31:0] sequence_res;
        logic [7:0]  out_type;
        logic [6:0]  out_size;
        logic [63:0] out_stamp;
        logic [11:0] occupancy;
        logic [31:0] oldest_sequence;
        logic [31:0] dropped_total;
        logic [31:0] rejected_total;
    } t_out;

    // one ring entry as held in the memory
    typedef struct packed {
        logic [31:0] seq;
        logic [7:0]  stype;
        logic [6:0]  size;
        logic [63:0] stamp;
    } t_entry;

endpackage

// ----- sv/acked_sample_retransmit_buffer.sv -----
// Retransmit buffer for acknowledged samples (go-back-N style).
// Input channel i_in_valid/o_in_ready carries one operation (store, select,
// frame done, acknowledge); output channel o_out_valid/i_out_ready returns one
// result per operation. The configuration write i_cfg_we/i_cfg_data sets the
// replay interval in milliseconds and may only be used while idle.
// Entries live in one single-port-write, one-read memory with a registered read
// port; the sequencer reads, compares and writes one entry a cycle.
// Path per operation: store, frame done, rejected ack and select on an empty
// ring go straight to the result state; select passes the head state, then
// scans up to SCAN_LIMIT entries; an accepted ack waits for the head read,
// then pops entries while seq <= ack.
// One operation is in flight at a time; the next one is taken the cycle after
// the result transfers. A stalled receiver holds the input off while the
// result stays unchanged. Reset clears the counters and the head pointer,
// sets the oldest sequence to 1 and loads an interval of 100 ms; entries
// are undefined until stored and need no clearing pass.
module acked_sample_retransmit_buffer #(
    parameter int RING_DEPTH = asrb_pkg::RingDepthDef,
    parameter int SCAN_LIMIT = asrb_pkg::ScanLimitDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  asrb_pkg::t_in     i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output asrb_pkg::t_out    o_out,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = $clog2(SCAN_LIMIT + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

    // entry memory
    asrb_pkg::t_entry mem [RING_DEPTH];
    logic             mem_we;
    logic [AW-1:0]    mem_wa, mem_ra;
    asrb_pkg::t_entry mem_wd, mem_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd <= mem[mem_ra];
    end

    asrb_pkg::t_state r_state, n_state;
    asrb_pkg::t_in    r_in, n_in;
    asrb_pkg::t_out   r_res, n_res;
    logic             r_ovalid, n_ovalid;
    logic [AW-1:0]    r_head, n_head, r_ptr, n_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic [SW-1:0]    r_scan, n_scan;
    logic [31:0]      r_last, n_last, r_cursor, n_cursor, r_replay, n_replay;
    logic [31:0]      r_pend, n_pend, r_high, n_high, r_drop, n_drop, r_rej, n_rej;
    logic [31:0]      r_oldest, n_oldest;
    logic [15:0]      r_intv;
    logic [31:0]      cur_eff;

    // slot index of ring offset, wraps over the depth
    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, a} + {1'b0, b};
        if (s >= {1'b0, DEPTH_C}) begin
            s = s - {1'b0, DEPTH_C};
        end
        return s[AW-1:0];
    endfunction

    assign o_in_ready  = (r_state == asrb_pkg::S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intv <= asrb_pkg::ReplayReset;
        end else if (i_cfg_we) begin
            r_intv <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= asrb_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
            r_scan   <= '0;
            r_last   <= '0;
            r_cursor <= '0;
            r_replay <= '0;
            r_pend   <= '0;
            r_high   <= '0;
            r_drop   <= '0;
            r_rej    <= '0;
            r_oldest <= 32'd1;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_head   <= n_head;
            r_count  <= n_count;
            r_scan   <= n_scan;
            r_last   <= n_last;
            r_cursor <= n_cursor;
            r_replay <= n_replay;
            r_pend   <= n_pend;
            r_high   <= n_high;
            r_drop   <= n_drop;
            r_rej    <= n_rej;
            r_oldest <= n_oldest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_res  <= n_res;
        r_ptr  <= n_ptr;
    end

    // cursor as seen this scan step (rewind applied in S_HEAD)
    assign cur_eff = r_cursor;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_ptr    = r_ptr;
        n_scan   = r_scan;
        n_head   = r_head;
        n_count  = r_count;
        n_last   = r_last;
        n_cursor = r_cursor;
        n_replay = r_replay;
        n_pend   = r_pend;
        n_high   = r_high;
        n_drop   = r_drop;
        n_rej    = r_rej;
        n_oldest = r_oldest;
        mem_we   = 1'b0;
        mem_wa   = ring_add(r_head, r_count);
        mem_wd   = '0;
        mem_ra   = r_ptr;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            asrb_pkg::S_IDLE: begin
                mem_ra = r_head;
                if (i_in_valid && o_in_ready) begin
                    n_in  = i_in;
                    n_res = '0;
                    n_state = asrb_pkg::S_DONE;
                    case (asrb_pkg::t_op'(i_in.op))
                        asrb_pkg::OP_STORE: begin
                            if (i_in.sample_size > asrb_pkg::MaxSize) begin
                                n_res.status = asrb_pkg::ST_OVERSIZE;
                            end else if (r_last == asrb_pkg::SeqLast) begin
                                n_drop = r_drop + 32'd1;
                                n_res.status = asrb_pkg::ST_EXHAUSTED;
                            end else begin
                                n_last = r_last + 32'd1;
                                n_res.sequence_res = r_last + 32'd1;
                                if (r_count >= DEPTH_C) begin
                                    n_drop = r_drop + 32'd1;
                                    n_res.status = asrb_pkg::ST_FULL;
                                end else begin
                                    mem_we = 1'b1;
                                    mem_wd.seq   = r_last + 32'd1;
                                    mem_wd.stype = i_in.sample_type;
                                    mem_wd.size  = i_in.sample_size[6:0];
                                    mem_wd.stamp = i_in.sample_stamp;
                                    n_res.slot = 11'(ring_add(r_head, r_count));
                                    n_count = r_count + CW'(1);
                                    if (r_count == '0) begin
                                        n_oldest = r_last + 32'd1;
                                    end
                                end
                            end
                            if (r_count == '0 && !(r_count < DEPTH_C &&
                                i_in.sample_size <= asrb_pkg::MaxSize &&
                                r_last != asrb_pkg::SeqLast)) begin
                                n_oldest = n_last + 32'd1;
                            end
                        end
                        asrb_pkg::OP_SELECT: begin
                            if (r_count == '0) begin
                                n_res.status = asrb_pkg::ST_NOTHING;
                            end else begin
                                n_state = asrb_pkg::S_HEAD;
                            end
                        end
                        asrb_pkg::OP_FRAME: begin
                            if (r_pend != '0) begin
                                if (i_in.frame_completed && r_pend > r_high) begin
                                    n_high = r_pend;
                                end
                                n_pend = '0;
                            end
                        end
                        default: begin
                            if (i_in.ack_sequence <= r_high) begin
                                n_state = asrb_pkg::S_POP;
                                n_ptr = r_head;
                            end else begin
                                n_rej = r_rej + 32'd1;
                                n_res.status = asrb_pkg::ST_REJECTED;
                            end
                        end
                    endcase
                end
            end
            // head entry is on mem_rd: rewind check, start scan at head
            asrb_pkg::S_HEAD: begin
                if ((r_in.now_ms - r_replay) >= {16'd0, r_intv}) begin
                    n_cursor = mem_rd.seq;
                    n_replay = r_in.now_ms;
                end
                n_ptr  = r_head;
                mem_ra = r_head;
                n_scan = '0;
                n_state = asrb_pkg::S_SCAN;
            end
            // mem_rd holds entry at r_ptr; look ahead one address
            asrb_pkg::S_SCAN: begin
                mem_ra = ring_add(r_ptr, CW'(1));
                n_ptr  = ring_add(r_ptr, CW'(1));
                n_scan = r_scan + SW'(1);
                if (mem_rd.seq >= cur_eff) begin
                    n_res.slot         = 11'(r_ptr);
                    n_res.sequence_res = mem_rd.seq;
                    n_res.out_type     = mem_rd.stype;
                    n_res.out_size     = mem_rd.size;
                    n_res.out_stamp    = mem_rd.stamp;
                    n_cursor = mem_rd.seq + 32'd1;
                    n_pend   = mem_rd.seq;
                    n_state  = asrb_pkg::S_DONE;
                end else if (CW'(r_scan) + CW'(1) >= r_count ||
                             r_scan + SW'(1) >= SW'(SCAN_LIMIT)) begin
                    n_res.status = asrb_pkg::ST_NOTHING;
                    n_state = asrb_pkg::S_DONE;
                end
            end
            // first wait for the head read, then pop while seq <= ack
            asrb_pkg::S_POP: begin
                mem_ra = r_head;
                if (r_ptr != r_head || r_scan == SW'(1)) begin
                    if (r_count != '0 && mem_rd.seq <= r_in.ack_sequence) begin
                        n_head  = ring_add(r_head, CW'(1));
                        n_count = r_count - CW'(1);
                        mem_ra  = ring_add(r_head, CW'(1));
                        n_ptr   = r_head;
                    end else begin
                        if (r_count != '0) begin
                            n_oldest = mem_rd.seq;
                        end else begin
                            n_oldest = r_last + 32'd1;
                        end
                        n_state = asrb_pkg::S_DONE;
                    end
                end else begin
                    n_scan = SW'(1);
                    n_ptr  = r_head;
                end
            end
            default: begin
                n_res.occupancy       = 12'(r_count);
                n_res.oldest_sequence = r_oldest;
                n_res.dropped_total   = r_drop;
                n_res.rejected_total  = r_rej;
                n_ovalid = 1'b1;
                n_scan   = '0;
                n_state  = asrb_pkg::S_IDLE;
            end
        endcase
    end

`include "assert_macros.svh"
    `AST_IMPL(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == asrb_pkg::S_IDLE, "ready outside idle")
    `AST_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C, "count over depth")
    `AST_IMPL(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, ##1 $stable(o_out), "result changed under stall")
    `AST_IMPL(a_drop_step, i_clk, i_rst_n, r_state == asrb_pkg::S_IDLE && !(i_in_valid && o_in_ready), ##1 $stable(r_drop), "drop count moved while idle")

endmodule
